// ----- src/graph_store_with_cycle_check_top_assert.svh -----
// Assertion macros for the graph store top level
`ifndef GRAPH_STORE_WITH_CYCLE_CHECK_TOP_ASSERT_SVH
`define GRAPH_STORE_WITH_CYCLE_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define GSCC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("graph store assertion failed");

// next-cycle implication
`define GSCC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("graph store assertion failed");

`endif

// ----- src/gscc_pkg.sv -----
`default_nettype none
package gscc_pkg;

	// defaults for the top-level table sizes
	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 128;

	// fixed field widths
	localparam int ID_BITS   = 16;
	localparam int PORT_BITS = 4;
	localparam logic [PORT_BITS-1:0] MAX_PORTS = 4'd15;

	// command codes
	localparam logic [2:0] CMD_ADD_NODE = 3'd0;
	localparam logic [2:0] CMD_DEL_NODE = 3'd1;
	localparam logic [2:0] CMD_CONNECT  = 3'd2;
	localparam logic [2:0] CMD_DEL_EDGE = 3'd3;
	localparam logic [2:0] CMD_CHECK    = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_REJECT    = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]           command;
		logic [ID_BITS-1:0]   item_id;
		logic [ID_BITS-1:0]   target_node;
		logic [PORT_BITS-1:0] source_port;
		logic [PORT_BITS-1:0] target_port;
		logic [PORT_BITS-1:0] input_port_count;
		logic [PORT_BITS-1:0] output_port_count;
	} gscc_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ID_BITS-1:0] new_id;
		logic               has_cycle;
	} gscc_out_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_NODE_RD,
		OP_NODE_EV,
		OP_NODE_ADD,
		OP_NODE_DEL,
		OP_EDGE_RD,
		OP_EDGE_EV,
		OP_EDGE_ADD,
		OP_EDGE_DEL,
		OP_CLR_DEG,
		OP_DEG_FETCH,
		OP_INC_WR,
		OP_DEC_WR,
		OP_DEG_RD,
		OP_DEG_EV,
		OP_POP,
		OP_POP_EV,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] status;
	} ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       self_loop;
		logic       nn_zero;
		logic       ne_zero;
		logic       node_live;
		logic       edge_live;
		logic       src_is_cur;
		logic       s_found;
		logic       d_found;
		logic       e_found;
		logic       dup;
		logic       port_bad;
		logic       stack_empty;
	} stat_t;

	// port count of a new node, held to 1..MAX_PORTS
	function automatic logic [PORT_BITS-1:0] clamp_ports(input logic [PORT_BITS-1:0] n);
		logic [PORT_BITS-1:0] r;
		if (n == '0)
			r = PORT_BITS'(1);
		else if (n > MAX_PORTS)
			r = MAX_PORTS;
		else
			r = n;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/gscc_ram.sv -----
`default_nettype none
module gscc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- src/gscc_dp.sv -----
`default_nettype none
module gscc_dp #(
	parameter int MAX_NODES = gscc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = gscc_pkg::MAX_EDGES_DEF,
	localparam int NB = $clog2(MAX_NODES),
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gscc_pkg::gscc_in_t  request,
	input  wire gscc_pkg::ctl_t      ctl,
	input  wire logic [NB-1:0]       nidx,
	input  wire logic [EB-1:0]       eidx,
	output gscc_pkg::stat_t          stat,
	output gscc_pkg::gscc_out_t      result
);
	import gscc_pkg::*;

	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int DW = $clog2(MAX_EDGES + 1);

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [PORT_BITS-1:0] in_ports;
		logic [PORT_BITS-1:0] out_ports;
	} node_t;

	// endpoints are kept as node slots; ids of live nodes are unique
	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [NB-1:0]        ss;
		logic [PORT_BITS-1:0] sp;
		logic [NB-1:0]        ds;
		logic [PORT_BITS-1:0] dp;
	} edge_t;

	gscc_in_t              req_q;
	logic [MAX_NODES-1:0]  nv_q;
	logic [MAX_EDGES-1:0]  ev_q;
	logic [ID_BITS-1:0]    next_node_q, next_edge_q, new_id_q;
	logic                  s_found_q, d_found_q, e_found_q, dup_q;
	logic [NB-1:0]         s_slot_q, d_slot_q, cur_q, dst_q;
	logic [PORT_BITS-1:0]  s_out_q, d_in_q;
	logic [EB-1:0]         e_slot_q;
	logic [CW-1:0]         total_q, visited_q, top_q;
	gscc_out_t             res_q;

	node_t                 nwr, nrd;
	edge_t                 ewr, erd;
	logic                  dwe, swe;
	logic [NB-1:0]         dwaddr, draddr, swdata;
	logic [DW-1:0]         dwdata, drd;
	logic [NB-1:0]         srd;

	// node table
	assign nwr = '{id: next_node_q, in_ports: clamp_ports(req_q.input_port_count),
		out_ports: clamp_ports(req_q.output_port_count)};

	gscc_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_nram (
		.clk(clk), .we(ctl.op == OP_NODE_ADD), .waddr(nidx), .wdata(nwr),
		.raddr(nidx), .rdata(nrd)
	);

	// edge table
	assign ewr = '{id: next_edge_q, ss: s_slot_q, sp: req_q.source_port,
		ds: d_slot_q, dp: req_q.target_port};

	gscc_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_eram (
		.clk(clk), .we(ctl.op == OP_EDGE_ADD), .waddr(e_slot_q), .wdata(ewr),
		.raddr(eidx), .rdata(erd)
	);

	// in-degree scratch
	always_comb begin
		dwe    = 1'b0;
		dwaddr = dst_q;
		dwdata = drd;
		unique case (ctl.op)
			OP_CLR_DEG: begin
				dwe    = 1'b1;
				dwaddr = nidx;
				dwdata = '0;
			end
			OP_INC_WR: begin
				dwe    = 1'b1;
				dwdata = drd + DW'(1);
			end
			OP_DEC_WR: begin
				dwe    = (drd != '0);
				dwdata = drd - DW'(1);
			end
			default: ;
		endcase
	end

	assign draddr = (ctl.op == OP_DEG_FETCH) ? erd.ds : nidx;

	gscc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dram (
		.clk(clk), .we(dwe), .waddr(dwaddr), .wdata(dwdata), .raddr(draddr), .rdata(drd)
	);

	// ready stack: push slots whose in-degree reaches zero
	always_comb begin
		swe    = 1'b0;
		swdata = nidx;
		if (ctl.op == OP_DEG_EV && nv_q[nidx] && drd == '0) begin
			swe = 1'b1;
		end else if (ctl.op == OP_DEC_WR && drd == DW'(1)) begin
			swe    = 1'b1;
			swdata = dst_q;
		end
	end

	gscc_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_sram (
		.clk(clk), .we(swe), .waddr(top_q[NB-1:0]), .wdata(swdata),
		.raddr(NB'(top_q - CW'(1))), .rdata(srd)
	);

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q       <= '0;
			nv_q        <= '0;
			ev_q        <= '0;
			next_node_q <= ID_BITS'(1);
			next_edge_q <= ID_BITS'(1);
			new_id_q    <= '0;
			s_found_q   <= 1'b0;
			d_found_q   <= 1'b0;
			e_found_q   <= 1'b0;
			dup_q       <= 1'b0;
			s_slot_q    <= '0;
			d_slot_q    <= '0;
			cur_q       <= '0;
			dst_q       <= '0;
			s_out_q     <= '0;
			d_in_q      <= '0;
			e_slot_q    <= '0;
			total_q     <= '0;
			visited_q   <= '0;
			top_q       <= '0;
			res_q       <= '0;
		end else begin
			if (swe)
				top_q <= top_q + CW'(1);
			unique case (ctl.op)
				OP_LOAD: begin
					req_q     <= request;
					new_id_q  <= '0;
					s_found_q <= 1'b0;
					d_found_q <= 1'b0;
					e_found_q <= 1'b0;
					dup_q     <= 1'b0;
					total_q   <= '0;
					visited_q <= '0;
					top_q     <= '0;
				end
				OP_NODE_EV: begin
					if (nv_q[nidx] && nrd.id == req_q.item_id) begin
						s_found_q <= 1'b1;
						s_slot_q  <= nidx;
						s_out_q   <= nrd.out_ports;
					end
					if (nv_q[nidx] && nrd.id == req_q.target_node) begin
						d_found_q <= 1'b1;
						d_slot_q  <= nidx;
						d_in_q    <= nrd.in_ports;
					end
				end
				OP_NODE_ADD: begin
					nv_q[nidx]  <= 1'b1;
					new_id_q    <= next_node_q;
					next_node_q <= next_node_q + ID_BITS'(1);
				end
				OP_NODE_DEL: nv_q[s_slot_q] <= 1'b0;
				OP_EDGE_EV: begin
					priority if (req_q.command == CMD_DEL_NODE) begin
						if (ev_q[eidx] && (erd.ss == s_slot_q || erd.ds == s_slot_q))
							ev_q[eidx] <= 1'b0;
					end else if (req_q.command == CMD_DEL_EDGE) begin
						if (ev_q[eidx] && erd.id == req_q.item_id && !e_found_q) begin
							e_found_q <= 1'b1;
							e_slot_q  <= eidx;
						end
					end else begin
						// connect: duplicate search and first free slot
						if (ev_q[eidx]) begin
							if (erd.ss == s_slot_q && erd.sp == req_q.source_port &&
								erd.ds == d_slot_q && erd.dp == req_q.target_port)
								dup_q <= 1'b1;
						end else if (!e_found_q) begin
							e_found_q <= 1'b1;
							e_slot_q  <= eidx;
						end
					end
				end
				OP_EDGE_ADD: begin
					ev_q[e_slot_q] <= 1'b1;
					new_id_q       <= next_edge_q;
					next_edge_q    <= next_edge_q + ID_BITS'(1);
				end
				OP_EDGE_DEL:  ev_q[e_slot_q] <= 1'b0;
				OP_CLR_DEG:   total_q <= total_q + CW'(nv_q[nidx]);
				OP_DEG_FETCH: dst_q <= erd.ds;
				OP_POP:       top_q <= top_q - CW'(1);
				OP_POP_EV: begin
					cur_q     <= srd;
					visited_q <= visited_q + CW'(1);
				end
				OP_DONE: begin
					res_q.status    <= ctl.status;
					res_q.new_id    <= new_id_q;
					res_q.has_cycle <= (req_q.command == CMD_CHECK) && (visited_q != total_q);
				end
				default: ;
			endcase
		end
	end

	// status back to the controller
	always_comb begin
		stat.cmd         = req_q.command;
		stat.self_loop   = (req_q.item_id == req_q.target_node);
		stat.nn_zero     = (next_node_q == '0);
		stat.ne_zero     = (next_edge_q == '0);
		stat.node_live   = nv_q[nidx];
		stat.edge_live   = ev_q[eidx];
		stat.src_is_cur  = (erd.ss == cur_q);
		stat.s_found     = s_found_q;
		stat.d_found     = d_found_q;
		stat.e_found     = e_found_q;
		stat.dup         = dup_q;
		stat.port_bad    = (req_q.source_port >= s_out_q) || (req_q.target_port >= d_in_q);
		stat.stack_empty = (top_q == '0);
	end

	assign result = res_q;

endmodule
`default_nettype wire

// ----- src/gscc_ctrl.sv -----
`default_nettype none
module gscc_ctrl #(
	parameter int MAX_NODES = gscc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = gscc_pkg::MAX_EDGES_DEF,
	localparam int NB = $clog2(MAX_NODES),
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire gscc_pkg::stat_t stat,
	output logic                 busy,
	output logic                 done,
	output gscc_pkg::ctl_t       ctl,
	output logic [NB-1:0]        nidx,
	output logic [EB-1:0]        eidx
);
	import gscc_pkg::*;

	localparam logic [NB-1:0] NLAST = NB'(MAX_NODES - 1);
	localparam logic [EB-1:0] ELAST = EB'(MAX_EDGES - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_ADD_SCAN, S_N_RD, S_N_EV, S_N_END,
		S_E_RD, S_E_EV, S_E_END, S_CLR, S_I_RD, S_I_EV, S_I_WR,
		S_R_RD, S_R_EV, S_POP, S_POP_EV, S_D_RD, S_D_EV, S_D_WR, S_DONE
	} state_t;

	state_t        state_q;
	logic [NB-1:0] nidx_q;
	logic [EB-1:0] eidx_q;
	logic [1:0]    st_q;
	logic          done_q;
	logic          inc_hit, dec_hit;

	assign inc_hit = stat.edge_live;
	assign dec_hit = stat.edge_live && stat.src_is_cur;

	// operation issued this cycle
	always_comb begin
		ctl.op     = OP_NONE;
		ctl.status = st_q;
		unique case (state_q)
			S_IDLE:     ctl.op = start ? OP_LOAD : OP_NONE;
			S_ADD_SCAN: ctl.op = stat.node_live ? OP_NONE : OP_NODE_ADD;
			S_N_RD:     ctl.op = OP_NODE_RD;
			S_N_EV:     ctl.op = OP_NODE_EV;
			S_E_RD,
			S_I_RD,
			S_D_RD:     ctl.op = OP_EDGE_RD;
			S_E_EV:     ctl.op = OP_EDGE_EV;
			S_E_END: begin
				priority if (stat.cmd == CMD_DEL_NODE)
					ctl.op = OP_NODE_DEL;
				else if (stat.cmd == CMD_DEL_EDGE)
					ctl.op = stat.e_found ? OP_EDGE_DEL : OP_NONE;
				else
					ctl.op = (!stat.dup && stat.e_found && !stat.ne_zero) ?
						OP_EDGE_ADD : OP_NONE;
			end
			S_CLR:      ctl.op = OP_CLR_DEG;
			S_I_EV:     ctl.op = inc_hit ? OP_DEG_FETCH : OP_NONE;
			S_I_WR:     ctl.op = OP_INC_WR;
			S_R_RD:     ctl.op = OP_DEG_RD;
			S_R_EV:     ctl.op = OP_DEG_EV;
			S_POP:      ctl.op = stat.stack_empty ? OP_NONE : OP_POP;
			S_POP_EV:   ctl.op = OP_POP_EV;
			S_D_EV:     ctl.op = dec_hit ? OP_DEG_FETCH : OP_NONE;
			S_D_WR:     ctl.op = OP_DEC_WR;
			S_DONE:     ctl.op = OP_DONE;
			default:    ctl.op = OP_NONE;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nidx_q  <= '0;
			eidx_q  <= '0;
			st_q    <= ST_OK;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					nidx_q <= '0;
					eidx_q <= '0;
					st_q   <= ST_OK;
					priority if (stat.cmd == CMD_ADD_NODE) begin
						if (stat.nn_zero) begin
							st_q    <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ADD_SCAN;
						end
					end else if (stat.cmd == CMD_DEL_NODE) begin
						state_q <= S_N_RD;
					end else if (stat.cmd == CMD_CONNECT) begin
						if (stat.self_loop) begin
							st_q    <= ST_REJECT;
							state_q <= S_DONE;
						end else begin
							state_q <= S_N_RD;
						end
					end else if (stat.cmd == CMD_DEL_EDGE) begin
						state_q <= S_E_RD;
					end else if (stat.cmd == CMD_CHECK) begin
						state_q <= S_CLR;
					end else begin
						state_q <= S_DONE;
					end
				end
				// first free node slot
				S_ADD_SCAN: begin
					if (!stat.node_live) begin
						state_q <= S_DONE;
					end else if (nidx_q == NLAST) begin
						st_q    <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						nidx_q <= nidx_q + NB'(1);
					end
				end
				// node id lookup
				S_N_RD: state_q <= S_N_EV;
				S_N_EV: begin
					if (nidx_q == NLAST) begin
						state_q <= S_N_END;
					end else begin
						nidx_q  <= nidx_q + NB'(1);
						state_q <= S_N_RD;
					end
				end
				S_N_END: begin
					if (stat.cmd == CMD_DEL_NODE) begin
						if (!stat.s_found) begin
							st_q    <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end else begin
							state_q <= S_E_RD;
						end
					end else if (!stat.s_found || !stat.d_found || stat.port_bad) begin
						st_q    <= ST_REJECT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_E_RD;
					end
				end
				// edge table sweep
				S_E_RD: state_q <= S_E_EV;
				S_E_EV: begin
					if (eidx_q == ELAST) begin
						state_q <= S_E_END;
					end else begin
						eidx_q  <= eidx_q + EB'(1);
						state_q <= S_E_RD;
					end
				end
				S_E_END: begin
					state_q <= S_DONE;
					priority if (stat.cmd == CMD_DEL_NODE) begin
						st_q <= ST_OK;
					end else if (stat.cmd == CMD_DEL_EDGE) begin
						st_q <= stat.e_found ? ST_OK : ST_NOT_FOUND;
					end else if (stat.dup) begin
						st_q <= ST_REJECT;
					end else if (!stat.e_found || stat.ne_zero) begin
						st_q <= ST_FULL;
					end else begin
						st_q <= ST_OK;
					end
				end
				// cycle check: clear in-degrees, count live nodes
				S_CLR: begin
					if (nidx_q == NLAST) begin
						nidx_q  <= '0;
						state_q <= S_I_RD;
					end else begin
						nidx_q <= nidx_q + NB'(1);
					end
				end
				// in-degree build
				S_I_RD: state_q <= S_I_EV;
				S_I_EV: begin
					if (inc_hit) begin
						state_q <= S_I_WR;
					end else if (eidx_q == ELAST) begin
						state_q <= S_R_RD;
					end else begin
						eidx_q  <= eidx_q + EB'(1);
						state_q <= S_I_RD;
					end
				end
				S_I_WR: begin
					if (eidx_q == ELAST) begin
						state_q <= S_R_RD;
					end else begin
						eidx_q  <= eidx_q + EB'(1);
						state_q <= S_I_RD;
					end
				end
				// seed the ready stack
				S_R_RD: state_q <= S_R_EV;
				S_R_EV: begin
					if (nidx_q == NLAST) begin
						state_q <= S_POP;
					end else begin
						nidx_q  <= nidx_q + NB'(1);
						state_q <= S_R_RD;
					end
				end
				// peel ready nodes
				S_POP: state_q <= stat.stack_empty ? S_DONE : S_POP_EV;
				S_POP_EV: begin
					eidx_q  <= '0;
					state_q <= S_D_RD;
				end
				S_D_RD: state_q <= S_D_EV;
				S_D_EV: begin
					if (dec_hit) begin
						state_q <= S_D_WR;
					end else if (eidx_q == ELAST) begin
						state_q <= S_POP;
					end else begin
						eidx_q  <= eidx_q + EB'(1);
						state_q <= S_D_RD;
					end
				end
				S_D_WR: begin
					if (eidx_q == ELAST) begin
						state_q <= S_POP;
					end else begin
						eidx_q  <= eidx_q + EB'(1);
						state_q <= S_D_RD;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign nidx = nidx_q;
	assign eidx = eidx_q;

endmodule
`default_nettype wire

// ----- src/graph_store_with_cycle_check_top.sv -----
`default_nettype none
// Graph store with cycle check. One command is taken when start is high and busy
// is low; its single result appears on result for exactly one cycle with done high,
// and must be captured then, as there is no way to hold it. Commands run one at a
// time through a sequencer that walks the node and edge tables one entry per read,
// each table having one read port. Add node scans for the first free node slot;
// remove node and connect look up their ids in the node table, then sweep the edge
// table; remove edge sweeps the edge table alone. The cycle check clears in-degrees
// while counting live nodes, builds in-degrees, seeds the ready stack, then sweeps
// the edge table once per live node with no incoming path from a cycle. Storage
// starts empty after reset, with no clearing pass.
module graph_store_with_cycle_check_top #(
	parameter int MAX_NODES = gscc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = gscc_pkg::MAX_EDGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire gscc_pkg::gscc_in_t request,
	output logic                    busy,
	output logic                    done,
	output gscc_pkg::gscc_out_t     result
);
	import gscc_pkg::*;

	localparam int NB = $clog2(MAX_NODES);
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	ctl_t          ctl;
	stat_t         stat;
	logic [NB-1:0] nidx;
	logic [EB-1:0] eidx;

	gscc_ctrl #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.busy(busy), .done(done), .ctl(ctl), .nidx(nidx), .eidx(eidx)
	);

	gscc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .request(request), .ctl(ctl),
		.nidx(nidx), .eidx(eidx), .stat(stat), .result(result)
	);

`include "graph_store_with_cycle_check_top_assert.svh"

	// an accepted item always makes the block busy
	`GSCC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// the result strobe lands only once the sequencer is back at rest
	`GSCC_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	// one strobe per item
	`GSCC_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	// a new id is handed out only with an ok status
	`GSCC_ASSERT_IMPL(a_id_ok, clk, arst_n, done && result.new_id != '0, result.status == ST_OK)

endmodule
`default_nettype wire

// ----- test/gscc_checker.sv -----
`default_nettype none
module gscc_checker #(
	parameter int MAX_NODES = gscc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = gscc_pkg::MAX_EDGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire gscc_pkg::gscc_in_t request,
	input  wire logic               done,
	input  wire gscc_pkg::gscc_out_t result,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import gscc_pkg::*;

	// shadow copy of the graph tables
	logic                      nd_live [MAX_NODES];
	logic [ID_BITS-1:0]        nd_id   [MAX_NODES];
	logic [PORT_BITS-1:0]      nd_inp  [MAX_NODES];
	logic [PORT_BITS-1:0]      nd_outp [MAX_NODES];
	logic                      eg_live [MAX_EDGES];
	logic [ID_BITS-1:0]        eg_id   [MAX_EDGES];
	logic [ID_BITS+PORT_BITS-1:0] eg_src [MAX_EDGES];
	logic [ID_BITS+PORT_BITS-1:0] eg_dst [MAX_EDGES];
	logic [ID_BITS-1:0]        node_ctr;
	logic [ID_BITS-1:0]        edge_ctr;

	gscc_out_t expected_results[$];

	function automatic int node_slot(input logic [ID_BITS-1:0] id);
		if (id == '0)
			return -1;
		for (int i = 0; i < MAX_NODES; i++)
			if (nd_live[i] && nd_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic int edge_slot(input logic [ID_BITS-1:0] id);
		if (id == '0)
			return -1;
		for (int i = 0; i < MAX_EDGES; i++)
			if (eg_live[i] && eg_id[i] == id)
				return i;
		return -1;
	endfunction

	// Kahn's method: peel off nodes with no remaining in-edges
	function automatic logic graph_cyclic();
		int deg [MAX_NODES];
		int ready[$];
		int total;
		int seen;
		int slot;
		int d;
		total = 0;
		seen = 0;
		for (int i = 0; i < MAX_NODES; i++) begin
			deg[i] = 0;
			if (nd_live[i])
				total++;
		end
		for (int e = 0; e < MAX_EDGES; e++)
			if (eg_live[e]) begin
				d = node_slot(eg_dst[e][ID_BITS+PORT_BITS-1:PORT_BITS]);
				if (d >= 0)
					deg[d]++;
			end
		for (int i = 0; i < MAX_NODES; i++)
			if (nd_live[i] && deg[i] == 0)
				ready.push_back(i);
		while (ready.size() > 0) begin
			slot = ready.pop_back();
			seen++;
			for (int e = 0; e < MAX_EDGES; e++)
				if (eg_live[e] && eg_src[e][ID_BITS+PORT_BITS-1:PORT_BITS] == nd_id[slot]) begin
					d = node_slot(eg_dst[e][ID_BITS+PORT_BITS-1:PORT_BITS]);
					if (d >= 0 && deg[d] > 0) begin
						deg[d]--;
						if (deg[d] == 0)
							ready.push_back(d);
					end
				end
		end
		return seen != total;
	endfunction

	// apply one command to the shadow tables and queue its result
	task automatic apply_command(input gscc_in_t rq);
		gscc_out_t r;
		int s;
		int d;
		int free_slot;
		logic dup;
		logic [ID_BITS+PORT_BITS-1:0] skey;
		logic [ID_BITS+PORT_BITS-1:0] dkey;
		r = '0;
		case (rq.command)
			CMD_ADD_NODE: begin
				free_slot = -1;
				for (int i = 0; i < MAX_NODES; i++)
					if (!nd_live[i] && free_slot < 0)
						free_slot = i;
				if (free_slot < 0 || node_ctr == '0) begin
					r.status = ST_FULL;
				end else begin
					nd_live[free_slot] = 1'b1;
					nd_id[free_slot] = node_ctr;
					nd_inp[free_slot] = (rq.input_port_count == '0) ? 4'd1 : rq.input_port_count;
					nd_outp[free_slot] = (rq.output_port_count == '0) ? 4'd1 : rq.output_port_count;
					r.new_id = node_ctr;
					node_ctr = node_ctr + 1'b1;
				end
			end
			CMD_DEL_NODE: begin
				s = node_slot(rq.item_id);
				if (s < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int i = 0; i < MAX_EDGES; i++)
						if (eg_src[i][ID_BITS+PORT_BITS-1:PORT_BITS] == rq.item_id ||
						    eg_dst[i][ID_BITS+PORT_BITS-1:PORT_BITS] == rq.item_id)
							eg_live[i] = 1'b0;
					nd_live[s] = 1'b0;
				end
			end
			CMD_CONNECT: begin
				s = node_slot(rq.item_id);
				d = node_slot(rq.target_node);
				skey = {rq.item_id, rq.source_port};
				dkey = {rq.target_node, rq.target_port};
				if (rq.item_id == rq.target_node || s < 0 || d < 0) begin
					r.status = ST_REJECT;
				end else if (rq.source_port >= nd_outp[s] || rq.target_port >= nd_inp[d]) begin
					r.status = ST_REJECT;
				end else begin
					free_slot = -1;
					dup = 1'b0;
					for (int i = 0; i < MAX_EDGES; i++) begin
						if (eg_live[i]) begin
							if (eg_src[i] == skey && eg_dst[i] == dkey)
								dup = 1'b1;
						end else if (free_slot < 0) begin
							free_slot = i;
						end
					end
					if (dup) begin
						r.status = ST_REJECT;
					end else if (free_slot < 0 || edge_ctr == '0) begin
						r.status = ST_FULL;
					end else begin
						eg_live[free_slot] = 1'b1;
						eg_id[free_slot] = edge_ctr;
						eg_src[free_slot] = skey;
						eg_dst[free_slot] = dkey;
						r.new_id = edge_ctr;
						edge_ctr = edge_ctr + 1'b1;
					end
				end
			end
			CMD_DEL_EDGE: begin
				s = edge_slot(rq.item_id);
				if (s < 0)
					r.status = ST_NOT_FOUND;
				else
					eg_live[s] = 1'b0;
			end
			CMD_CHECK: begin
				r.has_cycle = graph_cyclic();
			end
			default: ;
		endcase
		expected_results.push_back(r);
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		gscc_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++)
				nd_live[i] = 1'b0;
			for (int i = 0; i < MAX_EDGES; i++) begin
				eg_live[i] = 1'b0;
				eg_src[i] = '0;
				eg_dst[i] = '0;
			end
			node_ctr = ID_BITS'(1);
			edge_ctr = ID_BITS'(1);
			expected_results.delete();
			errors = 0;
		end else begin
			// result first: it belongs to an item accepted earlier
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", result);
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status || result.new_id !== want.new_id ||
					    result.has_cycle !== want.has_cycle) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected st=%0d id=%0d cyc=%0d, got st=%0d id=%0d cyc=%0d",
								want.status, want.new_id, want.has_cycle,
								result.status, result.new_id, result.has_cycle);
					end
				end
			end
			if (start && !busy)
				apply_command(request);
		end
		pending = expected_results.size();
	end
endmodule
`default_nettype wire

// ----- test/tb_graph_store_with_cycle_check_top.sv -----
`default_nettype none
module tb_graph_store_with_cycle_check_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gscc_pkg::*;

	localparam int CYCLE_LIMIT = 100000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	gscc_in_t  request = '0;
	logic      busy;
	logic      done;
	gscc_out_t result;
	int        errors;
	int        pending;
	int        cycles = 0;
	logic      allow_idle = 1'b1;
	int        node_hi = 1;
	int        edge_hi = 1;

	graph_store_with_cycle_check_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .done(done), .result(result)
	);

	gscc_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// send one item; entered and left at a falling edge
	task automatic send_item(input logic [2:0] cmd, input int item, input int tgt,
			input int sp, input int tp, input int ic, input int oc);
		int gap;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request.command <= cmd;
		request.item_id <= item[15:0];
		request.target_node <= tgt[15:0];
		request.source_port <= sp[3:0];
		request.target_port <= tp[3:0];
		request.input_port_count <= ic[3:0];
		request.output_port_count <= oc[3:0];
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (cmd == CMD_ADD_NODE)
			node_hi++;
		if (cmd == CMD_CONNECT)
			edge_hi++;
		@(negedge clk);
	endtask

	// node id: mostly a recent one, sometimes 0 or anything
	function automatic int pick_node();
		int lo;
		int k;
		lo = (node_hi > 30) ? node_hi - 30 : 1;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 0;
		if (k == 1)
			return $urandom_range(0, 65535);
		return $urandom_range(lo, node_hi);
	endfunction

	function automatic int pick_edge();
		int lo;
		lo = (edge_hi > 40) ? edge_hi - 40 : 1;
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, 65535);
		return $urandom_range(lo, edge_hi);
	endfunction

	function automatic int pick_port();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 15);
		return $urandom_range(0, 2);
	endfunction

	function automatic int pick_count();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 15);
		return $urandom_range(3, 15);
	endfunction

	// one random command with a mix leaning toward connects
	task automatic random_item();
		int k;
		k = $urandom_range(0, 99);
		if (k < 20)
			send_item(CMD_ADD_NODE, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 15), $urandom_range(0, 15), pick_count(), pick_count());
		else if (k < 36)
			send_item(CMD_DEL_NODE, pick_node(), $urandom_range(0, 65535), 0, 0, 0, 0);
		else if (k < 76)
			send_item(CMD_CONNECT, pick_node(), pick_node(), pick_port(), pick_port(),
				$urandom_range(0, 15), $urandom_range(0, 15));
		else if (k < 88)
			send_item(CMD_DEL_EDGE, pick_edge(), 0, 0, 0, 0, 0);
		else if (k < 96)
			send_item(CMD_CHECK, $urandom_range(0, 65535), $urandom_range(0, 65535),
				0, 0, 0, 0);
		else
			send_item(3'($urandom_range(5, 7)), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), $urandom_range(0, 15));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty graph, unused codes, missing ids, refusals, a small cycle
		send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0);
		send_item(3'd5, 65535, 65535, 15, 15, 15, 15);
		send_item(3'd7, 0, 0, 0, 0, 0, 0);
		send_item(CMD_DEL_NODE, 0, 0, 0, 0, 0, 0);
		send_item(CMD_DEL_EDGE, 0, 0, 0, 0, 0, 0);
		send_item(CMD_ADD_NODE, 0, 0, 0, 0, 0, 0);
		send_item(CMD_ADD_NODE, 65535, 65535, 15, 15, 15, 15);
		send_item(CMD_ADD_NODE, 0, 0, 0, 0, 3, 1);
		send_item(CMD_CONNECT, 0, 0, 0, 0, 0, 0);
		send_item(CMD_CONNECT, 1, 1, 0, 0, 0, 0);
		send_item(CMD_CONNECT, 1, 9, 0, 0, 0, 0);
		send_item(CMD_CONNECT, 1, 2, 1, 0, 0, 0);
		send_item(CMD_CONNECT, 2, 1, 0, 1, 0, 0);
		send_item(CMD_CONNECT, 1, 2, 0, 0, 0, 0);
		send_item(CMD_CONNECT, 1, 2, 0, 0, 0, 0);
		send_item(CMD_CONNECT, 2, 1, 14, 0, 0, 0);
		send_item(CMD_CONNECT, 2, 3, 15, 2, 0, 0);
		send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0);
		send_item(CMD_DEL_EDGE, 2, 0, 0, 0, 0, 0);
		send_item(CMD_DEL_EDGE, 2, 0, 0, 0, 0, 0);
		send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0);
		send_item(CMD_DEL_NODE, 65535, 0, 0, 0, 0, 0);
		send_item(CMD_DEL_NODE, 1, 0, 0, 0, 0, 0);
		send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0);

		// random mix
		repeat (600)
			random_item();

		// fill both tables, hit the full status, then clear down
		repeat (70)
			send_item(CMD_ADD_NODE, 0, 0, 0, 0, pick_count(), pick_count());
		repeat (140)
			send_item(CMD_CONNECT, $urandom_range(node_hi - 64, node_hi - 1),
				$urandom_range(node_hi - 64, node_hi - 1), pick_port(), pick_port(), 0, 0);
		send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0);
		for (int i = node_hi - 70; i < node_hi; i += 2)
			send_item(CMD_DEL_NODE, i, 0, 0, 0, 0, 0);
		send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0);
		for (int i = node_hi - 69; i < node_hi; i += 2)
			send_item(CMD_DEL_NODE, i, 0, 0, 0, 0, 0);

		// closing stretch with no gaps
		allow_idle = 1'b0;
		repeat (100)
			random_item();
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
